@@ hdl/m3i_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; used by m3i_divbank and matrix3x3_inverse.
package m3i_pkg;

    localparam int ELEM_W  = 16;            // Q4.12 input element
    localparam int RES_W   = 32;            // Q16.16 result element
    localparam int NELEM   = 9;
    localparam int COF_W   = 33;            // difference of two 16x16 products
    localparam int PROD_W  = 32;
    localparam int DETP_W  = ELEM_W + COF_W;
    localparam int DET_W   = DETP_W + 2;
    localparam int DEN_W   = 48;            // |det| < 2^48
    localparam int MAG_W   = 32;            // |cofactor| <= 2^31
    localparam int QW      = 33;            // quotient bits of 2*|adj|*2^28/|det|
    localparam int DIV_STG = QW;
    localparam int FRONT_STG = 4;
    localparam int BANK_STG  = DIV_STG + 2; // prepare + divide + round
    localparam int NSTG      = FRONT_STG + BANK_STG;

    localparam logic [RES_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [RES_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic        [RES_W-1:0]  t_res;

endpackage

@@ hdl/m3i_divbank.sv @@
// Nine-lane pipelined restoring divider: adjugate / determinant in Q16.16,
// rounded and saturated, with identity override. Depends on m3i_pkg.
module m3i_divbank (
    input  logic                          i_clk,
    input  logic [m3i_pkg::BANK_STG-1:0]  i_en,
    input  m3i_pkg::t_cof                 i_cof [m3i_pkg::NELEM],
    input  m3i_pkg::t_det                 i_det,
    output m3i_pkg::t_res                 o_res [m3i_pkg::NELEM],
    output logic                          o_singular
);
    import m3i_pkg::*;

    logic [DEN_W-1:0] r_rem  [DIV_STG+1][NELEM];
    logic [QW-1:0]    r_quot [DIV_STG+1][NELEM];
    logic             r_neg  [DIV_STG+1][NELEM];
    logic             r_sat  [DIV_STG+1][NELEM];
    logic [DEN_W-1:0] r_den  [DIV_STG+1];
    logic             r_sing [DIV_STG+1];
    t_res             r_res  [NELEM];
    logic             r_osing;

    logic [DET_W-1:0] w_detmag;
    assign w_detmag = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_den[0]  <= w_detmag[DEN_W-1:0];
            r_sing[0] <= (i_det == '0);
        end
    end

    // Prepare: the dividend is |adj| << 29; its top bits seed the remainder.
    for (genvar l = 0; l < NELEM; l++) begin : g_prep
        logic [COF_W-1:0] w_m33;
        logic [MAG_W-1:0] w_mag;
        assign w_m33 = i_cof[l][COF_W-1] ? COF_W'(-i_cof[l]) : COF_W'(i_cof[l]);
        assign w_mag = w_m33[MAG_W-1:0];
        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_rem[0][l]  <= DEN_W'(w_mag[MAG_W-1:4]);
                r_quot[0][l] <= {w_mag[3:0], {(QW-4){1'b0}}};
                r_neg[0][l]  <= i_cof[l][COF_W-1] ^ i_det[DET_W-1];
                r_sat[0][l]  <= {{(DEN_W+4-MAG_W){1'b0}}, w_mag} >=
                                {w_detmag[DEN_W-1:0], 4'b0};
            end
        end
    end

    for (genvar s = 1; s <= DIV_STG; s++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_den[s]  <= r_den[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end
        for (genvar l = 0; l < NELEM; l++) begin : g_lane
            logic [DEN_W:0] w_r2;
            logic           w_ge;
            assign w_r2 = {r_rem[s-1][l], r_quot[s-1][l][QW-1]};
            assign w_ge = w_r2 >= {1'b0, r_den[s-1]};
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_rem[s][l]  <= w_ge ? DEN_W'(w_r2 - {1'b0, r_den[s-1]})
                                         : w_r2[DEN_W-1:0];
                    r_quot[s][l] <= {r_quot[s-1][l][QW-2:0], w_ge};
                    r_neg[s][l]  <= r_neg[s-1][l];
                    r_sat[s][l]  <= r_sat[s-1][l];
                end
            end
        end
    end

    // Round half away from zero, then clamp to the signed 32-bit range; a singular matrix gives the identity.
    for (genvar l = 0; l < NELEM; l++) begin : g_out
        logic [QW:0]   w_t1;
        logic [QW-1:0] w_q;
        logic          w_big;
        t_res          n_res;
        assign w_t1  = {1'b0, r_quot[DIV_STG][l]} + (QW+1)'(1);
        assign w_q   = w_t1[QW:1];
        assign w_big = r_sat[DIV_STG][l] || w_q[QW-1] || w_q[QW-2];
        always_comb begin
            if (r_sing[DIV_STG]) begin
                n_res = (l % 4 == 0) ? ONE_Q16 : '0;
            end else if (r_neg[DIV_STG][l]) begin
                n_res = w_big ? SAT_NEG : RES_W'(-w_q[RES_W-1:0]);
            end else begin
                n_res = w_big ? SAT_POS : w_q[RES_W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[BANK_STG-1]) begin
                r_res[l] <= n_res;
            end
        end
        assign o_res[l] = r_res[l];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[BANK_STG-1]) begin
            r_osing <= r_sing[DIV_STG];
        end
    end
    assign o_singular = r_osing;

endmodule

@@ hdl/matrix3x3_inverse.sv @@
// Top level of the 3x3 matrix inverse: cofactors, determinant, and the
// divider bank. Depends on m3i_pkg and m3i_divbank.
//
//  Channel  Dir  Payload (low bits first)               Handshake
//  s_axis   in   tdata: m00 m01 m02 m10 .. m22 (16b)    tvalid/tready
//  m_axis   out  tdata: r00 r01 .. r22 (32b); tuser: singular  tvalid/tready
//
// One matrix per cycle is accepted while the output is not stalled. The
// pipeline holds four cofactor/determinant stages, a prepare stage, the
// 33-step quotient pipeline and a rounding stage. Each stage advances when
// the next one is empty or advancing, so bubbles close up under a stall and
// no request is lost or repeated. Reset clears only the stage valid bits.
module matrix3x3_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [143:0]                  i_s_axis_tdata,  // m00,m01,..,m22
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [287:0]                  o_m_axis_tdata,  // r00,r01,..,r22
    output logic                          o_m_axis_tuser   // singular
);
    import m3i_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    t_elem m [NELEM];
    for (genvar j = 0; j < NELEM; j++) begin : g_unpack
        assign m[j] = i_s_axis_tdata[j*ELEM_W +: ELEM_W];
    end

    // Stage 0: the eighteen element products of the cofactors.
    logic signed [PROD_W-1:0] r_pa [NELEM];
    logic signed [PROD_W-1:0] r_pb [NELEM];
    t_elem                    r_abc0 [3];
    // Adjugate k = m[A]*m[B] - m[C]*m[D], transposed cofactor order.
    localparam int IA [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int IB [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int IC [NELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ID [NELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < NELEM; k++) begin
                r_pa[k] <= m[IA[k]] * m[IB[k]];
                r_pb[k] <= m[IC[k]] * m[ID[k]];
            end
            for (int k = 0; k < 3; k++) begin
                r_abc0[k] <= m[k];
            end
        end
    end

    // Stage 1: cofactors.
    t_cof  r_cof1 [NELEM];
    t_elem r_abc1 [3];
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int k = 0; k < NELEM; k++) begin
                r_cof1[k] <= COF_W'(r_pa[k]) - COF_W'(r_pb[k]);
            end
            r_abc1 <= r_abc0;
        end
    end

    // Stage 2: expansion of the determinant along the first row.
    t_cof                     r_cof2 [NELEM];
    logic signed [DETP_W-1:0] r_dp   [3];
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_cof2   <= r_cof1;
            r_dp[0]  <= r_abc1[0] * r_cof1[0];
            r_dp[1]  <= r_abc1[1] * r_cof1[3];
            r_dp[2]  <= r_abc1[2] * r_cof1[6];
        end
    end

    // Stage 3: determinant sum.
    t_cof r_cof3 [NELEM];
    t_det r_det;
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_cof3 <= r_cof2;
            r_det  <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
        end
    end

    t_res w_res [NELEM];
    logic w_sing;

    m3i_divbank u_divbank (
        .i_clk      (i_clk),
        .i_en       (w_en[NSTG-1:FRONT_STG]),
        .i_cof      (r_cof3),
        .i_det      (r_det),
        .o_res      (w_res),
        .o_singular (w_sing)
    );

    for (genvar j = 0; j < NELEM; j++) begin : g_pack
        assign o_m_axis_tdata[j*RES_W +: RES_W] = w_res[j];
    end
    assign o_m_axis_tuser  = w_sing;
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_s_axis_tready = w_en[0];

    a_sing_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            w_res[0] == ONE_Q16 && w_res[4] == ONE_Q16 && w_res[8] == ONE_Q16)
        else $error("singular result without identity diagonal");

    a_sing_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            w_res[1] == '0 && w_res[3] == '0 && w_res[7] == '0)
        else $error("singular result with nonzero off-diagonal");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld) && !i_m_axis_tready)
        else $error("input stalled while the pipeline has a free stage");

endmodule
